### design/tcb_pkg.sv
package tcb_pkg;

	// command codes
	localparam logic [1:0] CMD_PUT  = 2'd0;
	localparam logic [1:0] CMD_FILL = 2'd1;
	localparam logic [1:0] CMD_COPY = 2'd2;
	localparam logic [1:0] CMD_READ = 2'd3;

	// register indexes
	localparam logic [1:0] REG_FG   = 2'd0;
	localparam logic [1:0] REG_BG   = 2'd1;
	localparam logic [1:0] REG_COLS = 2'd2;
	localparam logic [1:0] REG_ROWS = 2'd3;

	localparam logic [23:0] RGB_MASK = 24'hFF_FFFF;

	// controller to datapath
	typedef struct packed {
		logic clear;      // write zero at clearing-pass cell
		logic load;       // latch command
		logic put;        // write put cell
		logic rd;         // issue read of sweep cell
		logic wr;         // write fill cell or shifted copy destination
		logic step;       // advance sweep
		logic rd_one;     // issue read of command cell
		logic respond;    // drive result
	} tcb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_done;
		logic last;       // sweep at final cell
		logic empty;      // rectangle empty
	} tcb_sts_t;

endpackage

### design/tcb_ctrl.sv
module tcb_ctrl
	import tcb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] kind,
	input  tcb_sts_t   sts,
	output tcb_cmd_t   cmd,
	output logic       busy
);

	typedef enum logic [7:0] {
		S_CLR  = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_DEC  = 8'b0000_0100,
		S_FILL = 8'b0000_1000,
		S_CRD  = 8'b0001_0000,
		S_CWR  = 8'b0010_0000,
		S_RD   = 8'b0100_0000,
		S_RSP  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			kind_q <= CMD_PUT;
		end else begin
			state_q <= state_d;
			if (start && !busy) kind_q <= kind;
		end
	end

	assign busy = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_CLR: begin
				cmd.clear = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				unique case (kind_q)
					CMD_PUT: begin
						cmd.put = 1'b1;
						state_d = S_RSP;
					end
					CMD_FILL: state_d = sts.empty ? S_RSP : S_FILL;
					CMD_COPY: state_d = sts.empty ? S_RSP : S_CRD;
					default: begin
						cmd.rd_one = 1'b1;
						state_d = S_RD;
					end
				endcase
			end
			S_FILL: begin
				cmd.wr = 1'b1;
				cmd.step = 1'b1;
				if (sts.last) state_d = S_RSP;
			end
			S_CRD: begin
				cmd.rd = 1'b1;
				state_d = S_CWR;
			end
			S_CWR: begin
				cmd.wr = 1'b1;
				cmd.step = 1'b1;
				state_d = sts.last ? S_RSP : S_CRD;
			end
			S_RD: state_d = S_RSP;
			S_RSP: begin
				cmd.respond = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### design/tcb_dp.sv
module tcb_dp
	import tcb_pkg::*;
#(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tcb_cmd_t           cmd,
	output tcb_sts_t           sts,
	input  logic [1:0]         kind,
	input  logic signed [9:0]  col,
	input  logic signed [9:0]  row,
	input  logic signed [8:0]  span_w,
	input  logic signed [8:0]  span_h,
	input  logic signed [8:0]  shift_x,
	input  logic signed [8:0]  shift_y,
	input  logic [20:0]        char_code,
	input  logic [7:0]         offset,
	input  logic               vertical,
	input  logic [23:0]        fg_color,
	input  logic [23:0]        bg_color,
	input  logic [7:0]         cols_in_use,
	input  logic [6:0]         rows_in_use,
	output logic               done,
	output logic               ok,
	output logic [20:0]        char_out,
	output logic [23:0]        bg_out,
	output logic [23:0]        fg_out
);

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int AW = CW + RW;
	// store covers the full {row, col} address space
	localparam int CELLS = 1 << AW;
	localparam logic signed [12:0] MAXC = 13'(MAX_COLS);
	localparam logic signed [12:0] MAXR = 13'(MAX_ROWS);

	// one memory per word kind; copies run in place (see below)
	logic [20:0] char_mem [CELLS];
	logic [47:0] colr_mem [CELLS];

	logic signed [12:0] scr_w, scr_h;
	assign scr_w = ($signed({5'd0, cols_in_use}) > MAXC) ? MAXC : $signed({5'd0, cols_in_use});
	assign scr_h = ($signed({6'd0, rows_in_use}) > MAXR) ? MAXR : $signed({6'd0, rows_in_use});

	// latched command
	logic [1:0]          kind_q;
	logic signed [12:0]  x_q, y_q, tx_q, ty_q, x1_q, y1_q, x0_q, y0_q;
	logic [20:0]         ch_q;
	logic [7:0]          off_q;
	logic                vert_q;

	logic signed [12:0] xi, yi, wi, hi;
	assign xi = 13'(col) - 13'sd1;
	assign yi = 13'(row) - 13'sd1;
	assign wi = 13'(span_w);
	assign hi = 13'(span_h);

	logic signed [12:0] xe, ye;
	always_comb begin
		xe = xi + wi;
		ye = yi + hi;
	end

	// sweep position and direction; copies step backwards where needed
	logic signed [12:0] cx_q, cy_q;
	logic               rev_x_q, rev_y_q;
	logic [AW:0]        clr_q;

	logic signed [12:0] xs, xf, ys, yf;
	assign xs = rev_x_q ? x1_q - 13'sd1 : x0_q;
	assign xf = rev_x_q ? x0_q : x1_q - 13'sd1;
	assign ys = rev_y_q ? y1_q - 13'sd1 : y0_q;
	assign yf = rev_y_q ? y0_q : y1_q - 13'sd1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			x_q <= xi;
			y_q <= yi;
			x0_q <= (xi < 0) ? 13'sd0 : xi;
			y0_q <= (yi < 0) ? 13'sd0 : yi;
			x1_q <= (xe < scr_w) ? xe : scr_w;
			y1_q <= (ye < scr_h) ? ye : scr_h;
			tx_q <= 13'(shift_x);
			ty_q <= 13'(shift_y);
			rev_x_q <= (shift_x > 0);
			rev_y_q <= (shift_y > 0);
			ch_q <= char_code;
			off_q <= offset;
			vert_q <= vertical;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
		end else begin
			if (cmd.clear && !clr_q[AW]) clr_q <= clr_q + 1'b1;
			if (cmd.load) begin
				// start values set in decode cycle below
				cx_q <= '0;
				cy_q <= '0;
			end else if (!cmd.step && !cmd.rd && !cmd.wr) begin
				cx_q <= xs;
				cy_q <= ys;
			end else if (cmd.step) begin
				if (cx_q == xf) begin
					cx_q <= xs;
					cy_q <= rev_y_q ? cy_q - 13'sd1 : cy_q + 13'sd1;
				end else begin
					cx_q <= rev_x_q ? cx_q - 13'sd1 : cx_q + 13'sd1;
				end
			end
		end
	end

	logic empty;
	assign empty = (x0_q >= x1_q) || (y0_q >= y1_q);
	assign sts.clr_done = (clr_q == (AW+1)'(CELLS - 1)) || clr_q[AW];
	assign sts.last = (cx_q == xf) && (cy_q == yf);
	assign sts.empty = empty;

	// put position
	logic signed [12:0] px, py;
	assign px = vert_q ? x_q : x_q + 13'(off_q);
	assign py = vert_q ? y_q + 13'(off_q) : y_q;

	function automatic logic on_scr(input logic signed [12:0] a, input logic signed [12:0] b,
		input logic signed [12:0] w, input logic signed [12:0] h);
		return (a >= 0) && (b >= 0) && (a < w) && (b < h);
	endfunction

	function automatic logic [AW-1:0] idx(input logic signed [12:0] a,
		input logic signed [12:0] b);
		logic [12:0] ua, ub;
		ua = a;
		ub = b;
		return {ub[RW-1:0], ua[CW-1:0]};
	endfunction

	logic signed [12:0] dx, dy;
	assign dx = cx_q + tx_q;
	assign dy = cy_q + ty_q;

	// memory port: one write, one registered read
	logic            we;
	logic [AW-1:0]   wa, ra;
	logic [20:0]     wch, rch_q;
	logic [47:0]     wcl, rcl_q;
	logic            rd_en;
	logic            hit_q;

	always_comb begin
		we = 1'b0;
		wa = '0;
		wch = ch_q;
		wcl = {bg_color & RGB_MASK, fg_color & RGB_MASK};
		if (cmd.clear) begin
			we = !clr_q[AW];
			wa = clr_q[AW-1:0];
			wch = '0;
			wcl = '0;
		end else if (cmd.put) begin
			we = on_scr(px, py, scr_w, scr_h);
			wa = idx(px, py);
		end else if (cmd.wr && kind_q == CMD_FILL) begin
			we = 1'b1;
			wa = idx(cx_q, cy_q);
		end else if (cmd.wr) begin
			we = on_scr(dx, dy, scr_w, scr_h);
			wa = idx(dx, dy);
			wch = rch_q;
			wcl = rcl_q;
		end
	end

	assign rd_en = cmd.rd || cmd.rd_one;
	assign ra = cmd.rd_one ? idx(x_q, y_q) : idx(cx_q, cy_q);

	always_ff @(posedge clk) begin
		if (we) begin
			char_mem[wa] <= wch;
			colr_mem[wa] <= wcl;
		end
		if (rd_en) begin
			rch_q <= char_mem[ra];
			rcl_q <= colr_mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hit_q <= 1'b0;
		else if (cmd.rd_one) hit_q <= on_scr(x_q, y_q, scr_w, scr_h);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
			ok <= 1'b0;
			char_out <= '0;
			bg_out <= '0;
			fg_out <= '0;
		end else begin
			done <= cmd.respond;
			if (cmd.respond) begin
				if (kind_q == CMD_READ && hit_q) begin
					ok <= 1'b1;
					char_out <= rch_q;
					bg_out <= rcl_q[47:24];
					fg_out <= rcl_q[23:0];
				end else begin
					ok <= (kind_q != CMD_READ);
					char_out <= '0;
					bg_out <= '0;
					fg_out <= '0;
				end
			end
		end
	end

endmodule

### design/text_cell_blitter.sv
// Fill writes each cell of the clipped rectangle; copy reads and then writes
// each clipped source cell, as the store read is registered.
// One command at a time: busy stays high until the done strobe.
// Reset: asynchronous; afterwards a clearing pass over every store entry
// (MAX_COLS*MAX_ROWS, each rounded up to a power of two) zeroes the cell store
// while busy is high. Results cannot be stalled.
module text_cell_blitter
	import tcb_pkg::*;
#(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        kind,
	input  logic signed [9:0] col,
	input  logic signed [9:0] row,
	input  logic signed [8:0] span_w,
	input  logic signed [8:0] span_h,
	input  logic signed [8:0] shift_x,
	input  logic signed [8:0] shift_y,
	input  logic [20:0]       char_code,
	input  logic [7:0]        offset,
	input  logic              vertical,
	output logic              done,
	output logic              ok,
	output logic [20:0]       char_out,
	output logic [23:0]       bg_out,
	output logic [23:0]       fg_out
);

	logic [23:0] fg_q, bg_q;
	logic [7:0]  cols_q;
	logic [6:0]  rows_q;
	tcb_cmd_t    cmd;
	tcb_sts_t    sts;

	assign pready = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= RGB_MASK;
			bg_q <= '0;
			cols_q <= 8'd128;
			rows_q <= 7'd64;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_FG:   fg_q <= pwdata[23:0];
				REG_BG:   bg_q <= pwdata[23:0];
				REG_COLS: cols_q <= pwdata[7:0];
				REG_ROWS: rows_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_FG:   prdata = {8'd0, fg_q};
			REG_BG:   prdata = {8'd0, bg_q};
			REG_COLS: prdata = {24'd0, cols_q};
			REG_ROWS: prdata = {25'd0, rows_q};
			default:  prdata = '0;
		endcase
	end

	tcb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(kind),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	tcb_dp #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.kind(kind), .col(col), .row(row), .span_w(span_w), .span_h(span_h),
		.shift_x(shift_x), .shift_y(shift_y), .char_code(char_code),
		.offset(offset), .vertical(vertical),
		.fg_color(fg_q), .bg_color(bg_q), .cols_in_use(cols_q), .rows_in_use(rows_q),
		.done(done), .ok(ok), .char_out(char_out), .bg_out(bg_out), .fg_out(fg_out)
	);

endmodule
